[rtl/dzfs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Depth zone follow steering package
// Shared widths, register indexes, command codes and interface structs.
// ----------------------------------------------------------------------------
package dzfs_pkg;

   localparam int MAX_WIDTH  = 1280;
   localparam int MAX_HEIGHT = 720;

   localparam int COL_W    = 11;
   localparam int LINE_W   = 10;
   localparam int DEPTH_W  = 16;
   localparam int TALLY_W  = 18;
   localparam int WARM_W   = 6;
   localparam int CMD_W    = 3;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [TALLY_W-1:0] TALLY_MAX = {TALLY_W{1'b1}};
   localparam logic [WARM_W-1:0]  WARM_MAX  = {WARM_W{1'b1}};

   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SIDE_MARGIN   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_GROUND_ROWS   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_CLOSE_MM      = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_FAR_MM        = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_WARMUP_FRAMES = 3'd6;

   localparam logic [CMD_W-1:0] CMD_WARMUP      = 3'd0;
   localparam logic [CMD_W-1:0] CMD_GO          = 3'd1;
   localparam logic [CMD_W-1:0] CMD_STOP        = 3'd2;
   localparam logic [CMD_W-1:0] CMD_LEFT_START  = 3'd3;
   localparam logic [CMD_W-1:0] CMD_RIGHT_START = 3'd4;
   localparam logic [CMD_W-1:0] CMD_WAITING     = 3'd5;
   localparam logic [CMD_W-1:0] CMD_RECENTRED   = 3'd6;

   typedef struct packed {
      logic [COL_W-1:0]   width;
      logic [LINE_W-1:0]  height;
      logic [LINE_W-1:0]  margin;
      logic [LINE_W-1:0]  ground;
      logic [DEPTH_W-1:0] close_mm;
      logic [DEPTH_W-1:0] far_mm;
      logic [WARM_W-1:0]  warmup;
      logic [COL_W-1:0]   rstart;
   } dzfs_cfg_type;

   typedef struct packed {
      logic inc_left;
      logic inc_right;
      logic inc_go;
      logic inc_stop;
      logic frame_end;
   } dzfs_sample_type;

endpackage

[rtl/dzfs_csr.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Configuration registers
// Holds the seven setup registers and the limits derived from them.
// ----------------------------------------------------------------------------
module dzfs_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_write_en,
   input  logic [dzfs_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [dzfs_pkg::CSR_DATA_W-1:0]  csr_data,
   output dzfs_pkg::dzfs_cfg_type           cfg
);
   import dzfs_pkg::*;

   logic [COL_W-1:0]   frame_width_ff;
   logic [LINE_W-1:0]  frame_height_ff;
   logic [LINE_W-1:0]  side_margin_ff;
   logic [LINE_W-1:0]  ground_rows_ff;
   logic [DEPTH_W-1:0] close_mm_ff;
   logic [DEPTH_W-1:0] far_mm_ff;
   logic [WARM_W-1:0]  warmup_frames_ff;
   logic [COL_W-1:0]   width_in, width_ff;
   logic [LINE_W-1:0]  height_in, height_ff;
   logic [COL_W-1:0]   rstart_in, rstart_ff;
   logic [COL_W-1:0]   margin_ext;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff   <= COL_W'(640);
         frame_height_ff  <= LINE_W'(480);
         side_margin_ff   <= LINE_W'(200);
         ground_rows_ff   <= LINE_W'(20);
         close_mm_ff      <= DEPTH_W'(1000);
         far_mm_ff        <= DEPTH_W'(1500);
         warmup_frames_ff <= WARM_W'(30);
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_FRAME_WIDTH:   frame_width_ff   <= csr_data[COL_W-1:0];
            CSR_FRAME_HEIGHT:  frame_height_ff  <= csr_data[LINE_W-1:0];
            CSR_SIDE_MARGIN:   side_margin_ff   <= csr_data[LINE_W-1:0];
            CSR_GROUND_ROWS:   ground_rows_ff   <= csr_data[LINE_W-1:0];
            CSR_CLOSE_MM:      close_mm_ff      <= csr_data[DEPTH_W-1:0];
            CSR_FAR_MM:        far_mm_ff        <= csr_data[DEPTH_W-1:0];
            CSR_WARMUP_FRAMES: warmup_frames_ff <= csr_data[WARM_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      margin_ext = {1'b0, side_margin_ff};
      width_in   = (frame_width_ff > COL_W'(MAX_WIDTH)) ? COL_W'(MAX_WIDTH)
                                                        : frame_width_ff;
      height_in  = (frame_height_ff > LINE_W'(MAX_HEIGHT)) ? LINE_W'(MAX_HEIGHT)
                                                           : frame_height_ff;
      rstart_in  = (width_in > margin_ext) ? (width_in - margin_ext) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= COL_W'(640);
         height_ff <= LINE_W'(480);
         rstart_ff <= COL_W'(440);
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         rstart_ff <= rstart_in;
      end
   end

   assign cfg.width    = width_ff;
   assign cfg.height   = height_ff;
   assign cfg.margin   = side_margin_ff;
   assign cfg.ground   = ground_rows_ff;
   assign cfg.close_mm = close_mm_ff;
   assign cfg.far_mm   = far_mm_ff;
   assign cfg.warmup   = warmup_frames_ff;
   assign cfg.rstart   = rstart_ff;

endmodule

[rtl/dzfs_classify.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pixel classifier
// Registers each input beat, sorts the pixel into zones and registers the
// per-zone count increments for the tally stage.
// ----------------------------------------------------------------------------
module dzfs_classify (
   input  logic                              clock,
   input  logic                              reset,
   input  dzfs_pkg::dzfs_cfg_type            cfg,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [dzfs_pkg::COL_W-1:0]        req_column,
   input  logic [dzfs_pkg::LINE_W-1:0]       req_line,
   input  logic [dzfs_pkg::DEPTH_W-1:0]      req_depth_mm,
   input  logic                              req_frame_end,
   output logic                              smp_valid,
   output dzfs_pkg::dzfs_sample_type         smp,
   input  logic                              smp_ready
);
   import dzfs_pkg::*;

   logic                 in_valid_ff, in_valid_in;
   logic [COL_W-1:0]     col_ff;
   logic [LINE_W-1:0]    row_ff;
   logic [DEPTH_W-1:0]   depth_ff;
   logic                 fend_ff;
   logic                 smp_valid_ff, smp_valid_in;
   dzfs_sample_type      smp_ff, smp_in;
   logic                 stage2_ready, stage1_ready, accept;
   logic                 in_frame, in_band, too_close;
   logic                 left_hit, centre_hit, right_hit;
   logic [COL_W-1:0]     margin_ext;

   assign stage2_ready = !smp_valid_ff || smp_ready;
   assign stage1_ready = !in_valid_ff || stage2_ready;
   assign req_stall    = !stage1_ready;
   assign accept       = req_valid && stage1_ready;

   always_comb begin
      margin_ext = {1'b0, cfg.margin};
      in_frame   = (col_ff < cfg.width) && (row_ff < cfg.height) &&
                   (row_ff >= cfg.ground) && (row_ff[0] == cfg.ground[0]);
      in_band    = (depth_ff > cfg.close_mm) && (depth_ff < cfg.far_mm);
      too_close  = (depth_ff != '0) && (depth_ff < cfg.close_mm);
      left_hit   = (col_ff < margin_ext) && !col_ff[0];
      centre_hit = (col_ff >= margin_ext) && (col_ff < cfg.rstart) &&
                   (col_ff[0] == cfg.margin[0]);
      right_hit  = (col_ff >= cfg.rstart) && (col_ff[0] == cfg.rstart[0]);

      smp_in.inc_left  = in_frame && left_hit && in_band;
      smp_in.inc_right = in_frame && right_hit && in_band;
      smp_in.inc_go    = in_frame && centre_hit && in_band;
      smp_in.inc_stop  = in_frame && centre_hit && !in_band && too_close;
      smp_in.frame_end = fend_ff;

      in_valid_in  = stage1_ready ? req_valid : in_valid_ff;
      smp_valid_in = stage2_ready ? in_valid_ff : smp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         smp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         smp_valid_ff <= smp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         col_ff   <= req_column;
         row_ff   <= req_line;
         depth_ff <= req_depth_mm;
         fend_ff  <= req_frame_end;
      end
      if (stage2_ready && in_valid_ff) begin
         smp_ff <= smp_in;
      end
   end

   assign smp_valid = smp_valid_ff;
   assign smp       = smp_ff;

endmodule

[rtl/dzfs_decide.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tally and steering decision
// Keeps the four saturating zone tallies, and on each frame end picks the
// steering command, updates the turn state and loads the result register.
// ----------------------------------------------------------------------------
module dzfs_decide (
   input  logic                              clock,
   input  logic                              reset,
   input  dzfs_pkg::dzfs_cfg_type            cfg,
   input  logic                              smp_valid,
   input  dzfs_pkg::dzfs_sample_type         smp,
   output logic                              smp_ready,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [dzfs_pkg::CMD_W-1:0]        rsp_command,
   output logic                              rsp_left_active,
   output logic                              rsp_right_active,
   output logic [dzfs_pkg::TALLY_W-1:0]      rsp_left_count,
   output logic [dzfs_pkg::TALLY_W-1:0]      rsp_right_count,
   output logic [dzfs_pkg::TALLY_W-1:0]      rsp_go_count,
   output logic [dzfs_pkg::TALLY_W-1:0]      rsp_stop_count
);
   import dzfs_pkg::*;

   typedef enum logic [1:0] {
      MODE_NORMAL     = 2'd0,
      MODE_WAIT_LEFT  = 2'd1,
      MODE_WAIT_RIGHT = 2'd2
   } mode_type;

   mode_type             mode_ff, mode_in;
   logic [WARM_W-1:0]    warm_ff, warm_in;
   logic [TALLY_W-1:0]   left_ff, right_ff, go_ff, stop_ff;
   logic [TALLY_W-1:0]   left_nx, right_nx, go_nx, stop_nx;
   logic [TALLY_W-1:0]   left_in, right_in, go_in, stop_in;
   logic                 out_valid_ff, out_valid_in;
   logic [CMD_W-1:0]     cmd_ff, cmd_in;
   logic                 la_ff, la_in, ra_ff, ra_in;
   logic [TALLY_W-1:0]   lc_ff, rc_ff, gc_ff, sc_ff;
   logic                 out_busy, fire, load;
   logic [1:0]           best;
   logic [TALLY_W-1:0]   best_val;

   function automatic logic [TALLY_W-1:0] bump(input logic [TALLY_W-1:0] t,
                                                input logic inc);
      bump = (inc && t != TALLY_MAX) ? t + 1'b1 : t;
   endfunction

   assign out_busy  = out_valid_ff && rsp_stall;
   assign smp_ready = !(smp.frame_end && out_busy);
   assign fire      = smp_valid && smp_ready;
   assign load      = fire && smp.frame_end;

   always_comb begin
      left_nx  = bump(left_ff, smp.inc_left);
      right_nx = bump(right_ff, smp.inc_right);
      go_nx    = bump(go_ff, smp.inc_go);
      stop_nx  = bump(stop_ff, smp.inc_stop);

      best     = 2'd0;
      best_val = left_nx;
      if (right_nx > best_val) begin
         best     = 2'd1;
         best_val = right_nx;
      end
      if (go_nx > best_val) begin
         best     = 2'd2;
         best_val = go_nx;
      end
      if (stop_nx > best_val) begin
         best = 2'd3;
      end

      mode_in = mode_ff;
      warm_in = warm_ff;
      cmd_in  = CMD_WARMUP;
      la_in   = 1'b0;
      ra_in   = 1'b0;
      case (mode_ff)
         MODE_WAIT_LEFT, MODE_WAIT_RIGHT: begin
            if (best == 2'd2) begin
               cmd_in  = CMD_RECENTRED;
               mode_in = MODE_NORMAL;
            end else begin
               cmd_in = CMD_WAITING;
               la_in  = (mode_ff == MODE_WAIT_LEFT);
               ra_in  = (mode_ff == MODE_WAIT_RIGHT);
            end
         end
         default: begin
            if (warm_ff < cfg.warmup) begin
               cmd_in = CMD_WARMUP;
               if (warm_ff != WARM_MAX) begin
                  warm_in = warm_ff + 1'b1;
               end
            end else begin
               case (best)
                  2'd0: begin
                     cmd_in  = CMD_LEFT_START;
                     mode_in = MODE_WAIT_LEFT;
                     la_in   = 1'b1;
                  end
                  2'd1: begin
                     cmd_in  = CMD_RIGHT_START;
                     mode_in = MODE_WAIT_RIGHT;
                     ra_in   = 1'b1;
                  end
                  2'd2: begin
                     cmd_in  = CMD_GO;
                     mode_in = MODE_NORMAL;
                  end
                  default: begin
                     cmd_in  = CMD_STOP;
                     mode_in = MODE_NORMAL;
                  end
               endcase
            end
         end
      endcase

      if (fire && smp.frame_end) begin
         left_in  = '0;
         right_in = '0;
         go_in    = '0;
         stop_in  = '0;
      end else if (fire) begin
         left_in  = left_nx;
         right_in = right_nx;
         go_in    = go_nx;
         stop_in  = stop_nx;
      end else begin
         left_in  = left_ff;
         right_in = right_ff;
         go_in    = go_ff;
         stop_in  = stop_ff;
      end

      if (load) begin
         out_valid_in = 1'b1;
      end else if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_NORMAL;
         warm_ff      <= '0;
         left_ff      <= '0;
         right_ff     <= '0;
         go_ff        <= '0;
         stop_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         left_ff      <= left_in;
         right_ff     <= right_in;
         go_ff        <= go_in;
         stop_ff      <= stop_in;
         out_valid_ff <= out_valid_in;
         if (load) begin
            mode_ff <= mode_in;
            warm_ff <= warm_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         cmd_ff <= cmd_in;
         la_ff  <= la_in;
         ra_ff  <= ra_in;
         lc_ff  <= left_nx;
         rc_ff  <= right_nx;
         gc_ff  <= go_nx;
         sc_ff  <= stop_nx;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_command      = cmd_ff;
   assign rsp_left_active  = la_ff;
   assign rsp_right_active = ra_ff;
   assign rsp_left_count   = lc_ff;
   assign rsp_right_count  = rc_ff;
   assign rsp_go_count     = gc_ff;
   assign rsp_stop_count   = sc_ff;

endmodule

[rtl/depth_zone_follow_steering_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Depth zone follow steering
// Counts in-band depth samples in left, centre and right zones and turns
// each frame's counts into a steering command.
// ----------------------------------------------------------------------------
// The block takes one depth pixel beat per clock while req_stall is low, and
// produces one result beat on each pixel beat that carries frame_end. A pixel
// passes an input register, a classification register and the tally stage,
// which also loads the result register. Pixels without frame_end keep flowing
// while a result waits on rsp_stall; only a further frame_end beat waits for
// the result register to empty. Setup registers apply to beats accepted from
// the clock after a write.
module depth_zone_follow_steering_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write_en,
   input  logic [dzfs_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [dzfs_pkg::CSR_DATA_W-1:0]   csr_data,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [dzfs_pkg::COL_W-1:0]        req_column,
   input  logic [dzfs_pkg::LINE_W-1:0]       req_line,
   input  logic [dzfs_pkg::DEPTH_W-1:0]      req_depth_mm,
   input  logic                              req_frame_end,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [dzfs_pkg::CMD_W-1:0]        rsp_command,
   output logic                              rsp_left_active,
   output logic                              rsp_right_active,
   output logic [dzfs_pkg::TALLY_W-1:0]      rsp_left_count,
   output logic [dzfs_pkg::TALLY_W-1:0]      rsp_right_count,
   output logic [dzfs_pkg::TALLY_W-1:0]      rsp_go_count,
   output logic [dzfs_pkg::TALLY_W-1:0]      rsp_stop_count
);
   import dzfs_pkg::*;

   dzfs_cfg_type    cfg;
   dzfs_sample_type smp;
   logic            smp_valid;
   logic            smp_ready;

   dzfs_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .cfg          (cfg)
   );

   dzfs_classify u_classify (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_column    (req_column),
      .req_line      (req_line),
      .req_depth_mm  (req_depth_mm),
      .req_frame_end (req_frame_end),
      .smp_valid     (smp_valid),
      .smp           (smp),
      .smp_ready     (smp_ready)
   );

   dzfs_decide u_decide (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg),
      .smp_valid        (smp_valid),
      .smp              (smp),
      .smp_ready        (smp_ready),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_command      (rsp_command),
      .rsp_left_active  (rsp_left_active),
      .rsp_right_active (rsp_right_active),
      .rsp_left_count   (rsp_left_count),
      .rsp_right_count  (rsp_right_count),
      .rsp_go_count     (rsp_go_count),
      .rsp_stop_count   (rsp_stop_count)
   );

endmodule

[rtl/dzfs_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Port checker
// Watches the top level's result port for steering rule violations.
// ----------------------------------------------------------------------------
module dzfs_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              rsp_valid,
   input  logic                              rsp_stall,
   input  logic [dzfs_pkg::CMD_W-1:0]        rsp_command,
   input  logic                              rsp_left_active,
   input  logic                              rsp_right_active
);
   import dzfs_pkg::*;

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result beat shown right after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_command))
      else $error("stalled result beat changed");

   a_one_line: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_left_active && rsp_right_active))
      else $error("both turn lines active");

   a_start_lines: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_command == CMD_LEFT_START || rsp_command == CMD_RIGHT_START)
      |-> (rsp_left_active == (rsp_command == CMD_LEFT_START)) &&
          (rsp_right_active == (rsp_command == CMD_RIGHT_START)))
      else $error("turn line does not match turn start");

   a_idle_lines: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_command == CMD_WARMUP || rsp_command == CMD_GO ||
                    rsp_command == CMD_STOP || rsp_command == CMD_RECENTRED)
      |-> !rsp_left_active && !rsp_right_active)
      else $error("turn line active outside a turn");

endmodule

bind depth_zone_follow_steering_top dzfs_checker u_dzfs_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_command      (rsp_command),
   .rsp_left_active  (rsp_left_active),
   .rsp_right_active (rsp_right_active)
);

[tb/dzfs_steering_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Depth zone follow steering checker
// Watches the register port and both channels, keeps its own copy of the
// zone tallies, turn state and warm-up count, and compares every result beat
// field by field with the oldest frame verdict it has worked out.
// ----------------------------------------------------------------------------
module dzfs_steering_checker import dzfs_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  logic [COL_W-1:0]      req_column,
   input  logic [LINE_W-1:0]     req_line,
   input  logic [DEPTH_W-1:0]    req_depth_mm,
   input  logic                  req_frame_end,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  logic [CMD_W-1:0]      rsp_command,
   input  logic                  rsp_left_active,
   input  logic                  rsp_right_active,
   input  logic [TALLY_W-1:0]    rsp_left_count,
   input  logic [TALLY_W-1:0]    rsp_right_count,
   input  logic [TALLY_W-1:0]    rsp_go_count,
   input  logic [TALLY_W-1:0]    rsp_stop_count,
   output int                    error_count,
   output int                    pending_count,
   output int                    beat_count,
   output int                    result_count
);

   typedef enum logic [1:0] {TURN_NONE, TURN_LEFT, TURN_RIGHT} turn_t;
   typedef enum int {ZONE_LEFT, ZONE_RIGHT, ZONE_GO, ZONE_STOP} zone_t;

   typedef struct packed {
      logic [CMD_W-1:0]   command;
      logic               left_active;
      logic               right_active;
      logic [TALLY_W-1:0] left_count;
      logic [TALLY_W-1:0] right_count;
      logic [TALLY_W-1:0] go_count;
      logic [TALLY_W-1:0] stop_count;
   } frame_verdict_t;

   frame_verdict_t frame_verdicts[$];

   int cfg_width, cfg_height, cfg_margin, cfg_ground;
   int cfg_close, cfg_far, cfg_warmup;

   turn_t              turn;
   logic [WARM_W-1:0]  warm_seen;
   logic [TALLY_W-1:0] left_tally, right_tally, go_tally, stop_tally;

   initial begin
      error_count   = 0;
      pending_count = 0;
      beat_count    = 0;
      result_count  = 0;
   end

   task automatic bump(inout logic [TALLY_W-1:0] tally);
      if (tally != TALLY_MAX) tally = tally + 1'b1;
   endtask

   function automatic zone_t lead_zone();
      zone_t lead;
      int    best;
      lead = ZONE_LEFT;
      best = left_tally;
      if (right_tally > best) begin
         lead = ZONE_RIGHT;
         best = right_tally;
      end
      if (go_tally > best) begin
         lead = ZONE_GO;
         best = go_tally;
      end
      if (stop_tally > best) lead = ZONE_STOP;
      return lead;
   endfunction

   task automatic tally_pixel(input int col, input int row, input int depth, input bit fend);
      int             w, h, rstart;
      bit             in_band, too_close;
      zone_t          lead;
      frame_verdict_t verdict;
      w = cfg_width < MAX_WIDTH ? cfg_width : MAX_WIDTH;
      h = cfg_height < MAX_HEIGHT ? cfg_height : MAX_HEIGHT;
      rstart = w > cfg_margin ? w - cfg_margin : 0;
      if (col < w && row < h && row >= cfg_ground && (row - cfg_ground) % 2 == 0) begin
         in_band = depth > cfg_close && depth < cfg_far;
         too_close = depth > 0 && depth < cfg_close;
         if (col < cfg_margin && col % 2 == 0 && in_band) bump(left_tally);
         if (col >= cfg_margin && col < rstart && (col - cfg_margin) % 2 == 0) begin
            if (in_band) bump(go_tally);
            else if (too_close) bump(stop_tally);
         end
         if (col >= rstart && (col - rstart) % 2 == 0 && in_band) bump(right_tally);
      end
      if (fend) begin
         verdict = '0;
         lead = lead_zone();
         if (turn == TURN_LEFT || turn == TURN_RIGHT) begin
            if (lead == ZONE_GO) begin
               verdict.command = CMD_RECENTRED;
               turn = TURN_NONE;
            end else begin
               verdict.command = CMD_WAITING;
               verdict.left_active = turn == TURN_LEFT;
               verdict.right_active = turn == TURN_RIGHT;
            end
         end else if (int'(warm_seen) < cfg_warmup) begin
            verdict.command = CMD_WARMUP;
            if (warm_seen != WARM_MAX) warm_seen = warm_seen + 1'b1;
         end else begin
            case (lead)
               ZONE_LEFT: begin
                  verdict.command = CMD_LEFT_START;
                  verdict.left_active = 1'b1;
                  turn = TURN_LEFT;
               end
               ZONE_RIGHT: begin
                  verdict.command = CMD_RIGHT_START;
                  verdict.right_active = 1'b1;
                  turn = TURN_RIGHT;
               end
               ZONE_GO: begin
                  verdict.command = CMD_GO;
                  turn = TURN_NONE;
               end
               default: begin
                  verdict.command = CMD_STOP;
                  turn = TURN_NONE;
               end
            endcase
         end
         verdict.left_count = left_tally;
         verdict.right_count = right_tally;
         verdict.go_count = go_tally;
         verdict.stop_count = stop_tally;
         frame_verdicts.push_back(verdict);
         left_tally = '0;
         right_tally = '0;
         go_tally = '0;
         stop_tally = '0;
      end
   endtask

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         error_count++;
         if (error_count <= 10)
            $display("%0t: %s mismatch on result %0d: expected %0d, got %0d",
                     $time, name, result_count, want, got);
      end
   endtask

   always @(posedge clock) begin : watch
      frame_verdict_t want;
      if (reset) begin
         // Register values after reset.
         cfg_width = 640;
         cfg_height = 480;
         cfg_margin = 200;
         cfg_ground = 20;
         cfg_close = 1000;
         cfg_far = 1500;
         cfg_warmup = 30;
         turn = TURN_NONE;
         warm_seen = '0;
         left_tally = '0;
         right_tally = '0;
         go_tally = '0;
         stop_tally = '0;
         frame_verdicts.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            result_count++;
            if (frame_verdicts.size() == 0) begin
               error_count++;
               if (error_count <= 10)
                  $display("%0t: result beat %0d with no frame pending, command %0d",
                           $time, result_count, rsp_command);
            end else begin
               want = frame_verdicts.pop_front();
               check_field("command", want.command, rsp_command);
               check_field("left_active", want.left_active, rsp_left_active);
               check_field("right_active", want.right_active, rsp_right_active);
               check_field("left_count", want.left_count, rsp_left_count);
               check_field("right_count", want.right_count, rsp_right_count);
               check_field("go_count", want.go_count, rsp_go_count);
               check_field("stop_count", want.stop_count, rsp_stop_count);
            end
         end
         if (req_valid && !req_stall) begin
            beat_count++;
            tally_pixel(req_column, req_line, req_depth_mm, req_frame_end);
         end
         if (csr_write_en) begin
            case (csr_index)
               CSR_FRAME_WIDTH:   cfg_width = csr_data[COL_W-1:0];
               CSR_FRAME_HEIGHT:  cfg_height = csr_data[LINE_W-1:0];
               CSR_SIDE_MARGIN:   cfg_margin = csr_data[LINE_W-1:0];
               CSR_GROUND_ROWS:   cfg_ground = csr_data[LINE_W-1:0];
               CSR_CLOSE_MM:      cfg_close = csr_data[DEPTH_W-1:0];
               CSR_FAR_MM:        cfg_far = csr_data[DEPTH_W-1:0];
               CSR_WARMUP_FRAMES: cfg_warmup = csr_data[WARM_W-1:0];
               default: ;
            endcase
         end
      end
      pending_count = frame_verdicts.size();
   end

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Depth zone follow steering testbench
// Drives short depth frames aimed at each zone through the block under a
// series of register setups, with bursty input, patterned output stalls and
// a long output hold. The checker beside the block predicts and compares;
// this module gives the verdict.
// ----------------------------------------------------------------------------
module testbench;
   import dzfs_pkg::*;

   typedef enum int {AIM_LEFT, AIM_RIGHT, AIM_GO, AIM_STOP, AIM_NOISE} aim_t;
   typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_style_t;

   typedef struct {
      int width;
      int height;
      int margin;
      int ground;
      int near_mm;
      int far_mm;
      int warmup;
   } zone_setup_t;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_write_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [COL_W-1:0]      req_column = '0;
   logic [LINE_W-1:0]     req_line = '0;
   logic [DEPTH_W-1:0]    req_depth_mm = '0;
   logic                  req_frame_end = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [CMD_W-1:0]      rsp_command;
   logic                  rsp_left_active;
   logic                  rsp_right_active;
   logic [TALLY_W-1:0]    rsp_left_count;
   logic [TALLY_W-1:0]    rsp_right_count;
   logic [TALLY_W-1:0]    rsp_go_count;
   logic [TALLY_W-1:0]    rsp_stop_count;

   int error_count, pending_count, beat_count, result_count;

   zone_setup_t setup;
   int          burst_left = 0;
   int          items_sent = 0;
   int          setups_done = 0;
   bit          hold_request = 1'b0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   depth_zone_follow_steering_top i_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_column       (req_column),
      .req_line         (req_line),
      .req_depth_mm     (req_depth_mm),
      .req_frame_end    (req_frame_end),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_command      (rsp_command),
      .rsp_left_active  (rsp_left_active),
      .rsp_right_active (rsp_right_active),
      .rsp_left_count   (rsp_left_count),
      .rsp_right_count  (rsp_right_count),
      .rsp_go_count     (rsp_go_count),
      .rsp_stop_count   (rsp_stop_count)
   );

   dzfs_steering_checker i_checker (
      .clock            (clock),
      .reset            (reset),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_column       (req_column),
      .req_line         (req_line),
      .req_depth_mm     (req_depth_mm),
      .req_frame_end    (req_frame_end),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_command      (rsp_command),
      .rsp_left_active  (rsp_left_active),
      .rsp_right_active (rsp_right_active),
      .rsp_left_count   (rsp_left_count),
      .rsp_right_count  (rsp_right_count),
      .rsp_go_count     (rsp_go_count),
      .rsp_stop_count   (rsp_stop_count),
      .error_count      (error_count),
      .pending_count    (pending_count),
      .beat_count       (beat_count),
      .result_count     (result_count)
   );

   initial begin
      #2_000_000;
      $display("FAIL");
      $finish;
   end

   initial begin : receiver
      stall_style_t style;
      int           style_left;
      int           hold_cycles;
      style = STALL_NONE;
      style_left = 0;
      hold_cycles = 0;
      forever begin
         @(negedge clock);
         if (hold_request && hold_cycles == 0) begin
            hold_cycles = 300;
            hold_request = 1'b0;
         end
         if (style_left == 0) begin
            style = stall_style_t'($urandom_range(0, 3));
            style_left = $urandom_range(8, 80);
         end
         style_left--;
         if (hold_cycles > 0) begin
            hold_cycles--;
            rsp_stall <= 1'b1;
         end else begin
            case (style)
               STALL_NONE:  rsp_stall <= 1'b0;
               STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
               STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
               default:     rsp_stall <= (style_left % 5 == 0);
            endcase
         end
      end
   end

   task automatic send_beat(input int col, input int row, input int depth, input bit fend);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      if (burst_left > 0) burst_left--;
      req_valid <= 1'b1;
      req_column <= COL_W'(col);
      req_line <= LINE_W'(row);
      req_depth_mm <= DEPTH_W'(depth);
      req_frame_end <= fend;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   task automatic pick_pixel(input aim_t aim, output int col, output int row,
                             output int depth);
      int w, h, rstart, span, pick;
      w = setup.width < MAX_WIDTH ? setup.width : MAX_WIDTH;
      h = setup.height < MAX_HEIGHT ? setup.height : MAX_HEIGHT;
      rstart = w > setup.margin ? w - setup.margin : 0;
      span = w - 2 * setup.margin;
      row = setup.ground + 2 * $urandom_range(0, h > setup.ground + 1 ?
                                                 (h - setup.ground - 1) / 2 : 0);
      case (aim)
         AIM_LEFT:  col = 2 * $urandom_range(0, setup.margin > 1 ? (setup.margin - 1) / 2 : 0);
         AIM_RIGHT: col = rstart + 2 * $urandom_range(0, setup.margin / 2);
         AIM_GO, AIM_STOP: begin
            col = setup.margin + 2 * $urandom_range(0, span > 1 ? (span - 1) / 2 : 0);
         end
         default: begin
            col = $urandom_range(0, MAX_WIDTH - 1);
            row = $urandom_range(0, MAX_HEIGHT - 1);
         end
      endcase
      if (col > MAX_WIDTH - 1) col = MAX_WIDTH - 1;
      if (row > MAX_HEIGHT - 1) row = MAX_HEIGHT - 1;
      pick = $urandom_range(0, 9);
      if (aim == AIM_NOISE || pick == 0) begin
         depth = $urandom_range(0, 65535);
      end else if (pick == 1) begin
         case ($urandom_range(0, 3))
            0:       depth = 0;
            1:       depth = setup.near_mm;
            2:       depth = setup.far_mm;
            default: depth = 65535;
         endcase
      end else if (aim == AIM_STOP) begin
         depth = setup.near_mm > 1 ? $urandom_range(1, setup.near_mm - 1) :
                                     $urandom_range(0, 65535);
      end else begin
         depth = setup.far_mm > setup.near_mm + 1 ?
                 $urandom_range(setup.near_mm + 1, setup.far_mm - 1) :
                 $urandom_range(0, 65535);
      end
   endtask

   task automatic send_frame(input int max_len);
      int   len, col, row, depth;
      aim_t lead_aim, aim;
      len = $urandom_range(0, max_len);
      lead_aim = aim_t'($urandom_range(0, 3));
      for (int i = 0; i <= len; i++) begin
         case ($urandom_range(0, 9))
            0:       aim = AIM_NOISE;
            1, 2, 3: aim = aim_t'($urandom_range(0, 3));
            default: aim = lead_aim;
         endcase
         pick_pixel(aim, col, row, depth);
         send_beat(col, row, depth, i == len);
         items_sent++;
      end
   endtask

   task automatic drain_block();
      req_valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] index, input int value);
      csr_write_en <= 1'b1;
      csr_index <= index;
      csr_data <= CSR_DATA_W'(value);
      @(negedge clock);
   endtask

   task automatic write_setup(input zone_setup_t s);
      setup = s;
      write_reg(CSR_FRAME_WIDTH, s.width);
      write_reg(CSR_FRAME_HEIGHT, s.height);
      write_reg(CSR_SIDE_MARGIN, s.margin);
      write_reg(CSR_GROUND_ROWS, s.ground);
      write_reg(CSR_CLOSE_MM, s.near_mm);
      write_reg(CSR_FAR_MM, s.far_mm);
      write_reg(CSR_WARMUP_FRAMES, s.warmup);
      csr_write_en <= 1'b0;
      repeat (4) @(negedge clock);
      setups_done++;
   endtask

   initial begin : stimulus
      zone_setup_t s;
      int          phase, phase_start, phase_budget, max_len;
      repeat (7) @(negedge clock);
      reset <= 1'b0;
      setup = '{640, 480, 200, 20, 1000, 1500, 30};

      // One warm-up frame under the reset setup: every zone, band edges,
      // off-grid, above-ground and out-of-frame pixels.
      send_beat(0, 20, 1200, 1'b0);
      send_beat(1279, 719, 65535, 1'b0);
      send_beat(200, 20, 1001, 1'b0);
      send_beat(202, 22, 999, 1'b0);
      send_beat(440, 20, 1499, 1'b0);
      send_beat(441, 20, 1200, 1'b0);
      send_beat(0, 19, 1200, 1'b0);
      send_beat(200, 20, 1000, 1'b0);
      send_beat(200, 20, 1500, 1'b0);
      send_beat(300, 20, 0, 1'b1);
      drain_block();

      // An empty frame ties and starts a left turn, then recentre, stop,
      // right turn, waiting, recentre and go.
      write_setup('{16, 12, 4, 1, 100, 200, 0});
      send_beat(0, 0, 0, 1'b1);
      send_beat(4, 1, 150, 1'b1);
      send_beat(6, 1, 50, 1'b1);
      send_beat(12, 1, 150, 1'b1);
      send_beat(0, 1, 150, 1'b1);
      send_beat(4, 1, 150, 1'b1);
      send_beat(4, 1, 150, 1'b1);
      drain_block();

      // Left and right zones overlap.
      write_setup('{16, 12, 10, 1, 100, 200, 0});
      send_beat(6, 1, 150, 1'b1);
      drain_block();

      // Side margin wider than the frame puts the right zone at column zero.
      write_setup('{16, 12, 20, 1, 100, 200, 0});
      send_beat(2, 1, 150, 1'b0);
      send_beat(3, 1, 150, 1'b1);

      phase = 0;
      while (items_sent < 1050) begin
         drain_block();
         phase_budget = 120;
         if (phase == 0) begin
            s = '{1280, 720, 640, 0, 0, 65535, 63};
            max_len = 2;
            phase_budget = 220;
         end else if (phase == 1) begin
            s = '{0, 0, 0, 720, 65535, 0, 0};
            max_len = 6;
         end else begin
            s.width = $urandom_range(4, 48);
            s.height = $urandom_range(4, 24);
            s.margin = $urandom_range(0, s.width / 2 + 4);
            s.ground = $urandom_range(0, 4);
            s.near_mm = $urandom_range(0, 400);
            s.far_mm = $urandom_range(0, 5) == 0 ? $urandom_range(0, 400) :
                       s.near_mm + $urandom_range(0, 400);
            s.warmup = $urandom_range(0, 3);
            max_len = phase == 3 ? 1 : $urandom_range(3, 16);
         end
         write_setup(s);
         if (phase == 3) hold_request = 1'b1;
         phase_start = items_sent;
         while (items_sent - phase_start < phase_budget) begin
            send_frame(max_len);
            if (phase == 4 && $urandom_range(0, 7) == 0) drain_block();
         end
         phase++;
      end

      drain_block();
      $display("Covered %0d pixel beats and %0d steering results", beat_count, result_count);
      $display("over %0d register setups, with bursty input, stalled output and a long hold.",
               setups_done);
      if (error_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
